// ===== rtl/core/lsc_pkg.sv =====
// Shared constants, outcode bits and the outcode function for the line clipper.
// Used by lsc_front, lsc_back and line_segment_clipper_core.
package lsc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int MAX_W          = 48;
	localparam int MAX_STEPS      = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 3'd3;

	localparam int RST_X_MIN = 100;
	localparam int RST_Y_MIN = 100;
	localparam int RST_X_MAX = 300;
	localparam int RST_Y_MAX = 300;

	localparam logic [3:0] OC_TOP    = 4'd1;
	localparam logic [3:0] OC_BOTTOM = 4'd2;
	localparam logic [3:0] OC_RIGHT  = 4'd4;
	localparam logic [3:0] OC_LEFT   = 4'd8;

	typedef logic signed [MAX_W-1:0] wide_t;

	function automatic logic [3:0] outcode(input wide_t x, input wide_t y,
		input wide_t xl, input wide_t yl, input wide_t xh, input wide_t yh);
		logic [3:0] c;
		c = 4'd0;
		if (y > yh) c = c | OC_TOP;
		else if (y < yl) c = c | OC_BOTTOM;
		if (x > xh) c = c | OC_RIGHT;
		else if (x < xl) c = c | OC_LEFT;
		return c;
	endfunction

endpackage

// ===== rtl/core/lsc_front.sv =====
// Front end: takes a segment word, scales it to fixed point and computes both outcodes.
// Depends on lsc_pkg.
module lsc_front #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lsc_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [COORD_BITS-1:0]          start_x,
	input  logic signed [COORD_BITS-1:0]          start_y,
	input  logic signed [COORD_BITS-1:0]          end_x,
	input  logic signed [COORD_BITS-1:0]          end_y,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_xl,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_yl,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_xh,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_yh,
	input  logic                                  q_full,
	output logic                                  q_push,
	output logic [4*(COORD_BITS+FRAC_BITS)+7:0]   q_data
);
	localparam int W = COORD_BITS + FRAC_BITS;

	logic signed [W-1:0] fx1, fy1, fx2, fy2;
	logic [3:0] c1, c2;
	logic valid_s1;
	logic [4*W+7:0] data_s1;
	logic accept;

	assign fx1 = W'(start_x) <<< FRAC_BITS;
	assign fy1 = W'(start_y) <<< FRAC_BITS;
	assign fx2 = W'(end_x) <<< FRAC_BITS;
	assign fy2 = W'(end_y) <<< FRAC_BITS;

	assign c1 = lsc_pkg::outcode(lsc_pkg::wide_t'(fx1), lsc_pkg::wide_t'(fy1),
		lsc_pkg::wide_t'(win_xl), lsc_pkg::wide_t'(win_yl),
		lsc_pkg::wide_t'(win_xh), lsc_pkg::wide_t'(win_yh));
	assign c2 = lsc_pkg::outcode(lsc_pkg::wide_t'(fx2), lsc_pkg::wide_t'(fy2),
		lsc_pkg::wide_t'(win_xl), lsc_pkg::wide_t'(win_yl),
		lsc_pkg::wide_t'(win_xh), lsc_pkg::wide_t'(win_yh));

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= {fx1, fy1, fx2, fy2, c1, c2};
		end
	end

endmodule

// ===== rtl/core/lsc_fifo.sv =====
// Small register queue between the front and back ends.
// No package dependency.
module lsc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic do_wr, do_rd;

	assign q_full  = (count_q == CNT_BITS'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/core/lsc_muldiv.sv =====
// Shared iterative unit: a * b / den, signed, quotient truncated toward zero.
// Shift-add multiply (one bit a cycle) then restoring divide. No package dependency.
module lsc_muldiv #(
	parameter int OP_BITS = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [OP_BITS-1:0]     op_a,
	input  logic signed [OP_BITS-1:0]     op_b,
	input  logic signed [OP_BITS-1:0]     op_den,
	output logic                          done,
	output logic signed [2*OP_BITS-1:0]   quo
);
	localparam int PROD_BITS = 2 * OP_BITS;
	localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic neg_q, zero_q;
	logic [OP_BITS-1:0] mcand_q, dvs_q, rem_q;
	logic [PROD_BITS:0] prod_q;
	logic [OP_BITS:0] mul_sum, rem_sh, rem_sub;
	logic div_ge;
	logic [PROD_BITS-1:0] mag;

	function automatic logic [OP_BITS-1:0] mag_of(input logic signed [OP_BITS-1:0] v);
		return v[OP_BITS-1] ? OP_BITS'(-v) : OP_BITS'(v);
	endfunction

	assign mul_sum = prod_q[PROD_BITS:OP_BITS] + (prod_q[0] ? {1'b0, mcand_q} : '0);
	assign rem_sh  = {rem_q, prod_q[PROD_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign div_ge  = (rem_sh >= {1'b0, dvs_q});
	assign mag     = prod_q[PROD_BITS-1:0];
	assign done    = (state_q == ST_DONE);
	assign quo     = zero_q ? '0 : (neg_q ? -$signed(mag) : $signed(mag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == CNT_BITS'(OP_BITS - 1)) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_BITS'(PROD_BITS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mcand_q <= mag_of(op_a);
			prod_q  <= {{(OP_BITS + 1){1'b0}}, mag_of(op_b)};
			dvs_q   <= mag_of(op_den);
			rem_q   <= '0;
			neg_q   <= op_a[OP_BITS-1] ^ op_b[OP_BITS-1] ^ op_den[OP_BITS-1];
			zero_q  <= (op_den == '0);
		end else if (state_q == ST_MUL) begin
			prod_q <= {1'b0, mul_sum, prod_q[OP_BITS-1:1]};
		end else if (state_q == ST_DIV) begin
			// numerator bits leave at the top, quotient bits enter at the bottom
			rem_q  <= div_ge ? rem_sub[OP_BITS-1:0] : rem_sh[OP_BITS-1:0];
			prod_q <= {prod_q[PROD_BITS-1:0], div_ge};
		end
	end

endmodule

// ===== rtl/core/lsc_back.sv =====
// Back end: runs the clip steps for one segment word and holds the result word.
// Depends on lsc_pkg and lsc_muldiv.
module lsc_back #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lsc_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_xl,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_yl,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_xh,
	input  logic signed [COORD_BITS+FRAC_BITS-1:0] win_yh,
	input  logic                                   q_empty,
	output logic                                   q_pop,
	input  logic [4*(COORD_BITS+FRAC_BITS)+7:0]    q_data,
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   accepted,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_start_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_start_y,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_end_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_end_y
);
	localparam int W = COORD_BITS + FRAC_BITS;
	localparam int D = W + 1;
	localparam int P = 2 * D;
	localparam int STEP_BITS = $clog2(lsc_pkg::MAX_STEPS + 1);
	localparam logic signed [W-1:0] SAT_HI = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] SAT_LO = {1'b1, {(W - 1){1'b0}}};

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0] state_q;
	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q, edge_q, base_q;
	logic [3:0] c1_q, c2_q, co;
	logic [STEP_BITS-1:0] step_q;
	logic cross_x_q, move1_q;
	logic out_valid_q, acc_q;
	logic signed [W-1:0] ox1_q, oy1_q, ox2_q, oy2_q;

	logic signed [D-1:0] dx, dy, op_a, op_b, op_den;
	logic signed [W-1:0] edge_n, base_n, cross_v, nx, ny;
	logic cross_x_n, md_start, md_done;
	logic signed [P-1:0] md_quo;
	logic signed [P:0] sum;
	logic [3:0] ncode;
	logic done_in, rej_in;

	lsc_muldiv #(.OP_BITS(D)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.op_a   (op_a),
		.op_b   (op_b),
		.op_den (op_den),
		.done   (md_done),
		.quo    (md_quo)
	);

	assign q_pop = (state_q == ST_IDLE) && !q_empty && !out_valid_q;

	assign co  = (c1_q != 4'd0) ? c1_q : c2_q;
	assign dx  = D'(x2_q) - D'(x1_q);
	assign dy  = D'(y2_q) - D'(y1_q);
	assign done_in = (c1_q == 4'd0) && (c2_q == 4'd0);
	assign rej_in  = ((c1_q & c2_q) != 4'd0) || (step_q == STEP_BITS'(lsc_pkg::MAX_STEPS));
	assign md_start = (state_q == ST_EVAL) && !done_in && !rej_in;

	// edge priority: top, bottom, right, left
	always_comb begin
		priority if ((co & lsc_pkg::OC_TOP) != 4'd0) begin
			edge_n = win_yh; cross_x_n = 1'b1;
		end else if ((co & lsc_pkg::OC_BOTTOM) != 4'd0) begin
			edge_n = win_yl; cross_x_n = 1'b1;
		end else if ((co & lsc_pkg::OC_RIGHT) != 4'd0) begin
			edge_n = win_xh; cross_x_n = 1'b0;
		end else begin
			edge_n = win_xl; cross_x_n = 1'b0;
		end
		if (cross_x_n) begin
			op_a = dx; op_b = D'(edge_n) - D'(y1_q); op_den = dy; base_n = x1_q;
		end else begin
			op_a = dy; op_b = D'(edge_n) - D'(x1_q); op_den = dx; base_n = y1_q;
		end
	end

	assign sum = (P + 1)'(base_q) + (P + 1)'(md_quo);
	always_comb begin
		if (sum > (P + 1)'(SAT_HI)) cross_v = SAT_HI;
		else if (sum < (P + 1)'(SAT_LO)) cross_v = SAT_LO;
		else cross_v = sum[W-1:0];
		nx = cross_x_q ? cross_v : edge_q;
		ny = cross_x_q ? edge_q : cross_v;
	end
	assign ncode = lsc_pkg::outcode(lsc_pkg::wide_t'(nx), lsc_pkg::wide_t'(ny),
		lsc_pkg::wide_t'(win_xl), lsc_pkg::wide_t'(win_yl),
		lsc_pkg::wide_t'(win_xh), lsc_pkg::wide_t'(win_yh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EVAL;
						step_q  <= '0;
					end
				end
				ST_EVAL: begin
					if (done_in || rej_in) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (md_done) begin
						state_q <= ST_EVAL;
						step_q  <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			{x1_q, y1_q, x2_q, y2_q, c1_q, c2_q} <= q_data;
		end else if (state_q == ST_WAIT && md_done) begin
			if (move1_q) begin
				x1_q <= nx; y1_q <= ny; c1_q <= ncode;
			end else begin
				x2_q <= nx; y2_q <= ny; c2_q <= ncode;
			end
		end
		if (md_start) begin
			edge_q    <= edge_n;
			base_q    <= base_n;
			cross_x_q <= cross_x_n;
			move1_q   <= (c1_q != 4'd0);
		end
		if (state_q == ST_EVAL && (done_in || rej_in)) begin
			acc_q <= done_in;
			ox1_q <= done_in ? x1_q : '0;
			oy1_q <= done_in ? y1_q : '0;
			ox2_q <= done_in ? x2_q : '0;
			oy2_q <= done_in ? y2_q : '0;
		end
	end

	assign empty        = !out_valid_q;
	assign accepted     = acc_q;
	assign clip_start_x = ox1_q;
	assign clip_start_y = oy1_q;
	assign clip_end_x   = ox2_q;
	assign clip_end_y   = oy2_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_BITS'(lsc_pkg::MAX_STEPS))
		else $error("clip step count out of range");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !acc_q) |->
		(ox1_q == '0 && oy1_q == '0 && ox2_q == '0 && oy2_q == '0))
		else $error("rejected word has nonzero coordinates");

	a_accept_inside: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && acc_q |->
		(lsc_pkg::outcode(lsc_pkg::wide_t'(ox1_q), lsc_pkg::wide_t'(oy1_q),
			lsc_pkg::wide_t'(win_xl), lsc_pkg::wide_t'(win_yl),
			lsc_pkg::wide_t'(win_xh), lsc_pkg::wide_t'(win_yh)) == 4'd0))
		else $error("accepted start point lies outside window");

	a_wait_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> !out_valid_q)
		else $error("clip in progress while result word pending");

endmodule

// ===== rtl/core/line_segment_clipper_core.sv =====
// Cohen-Sutherland segment clipper against a four-register window, Q16.8 output.
// A segment takes 0..4 clip steps, each run on the shared shift-add multiply / restoring divide.
// The back end clips one segment at a time and takes the next only once its result word is popped;
// a two-word queue lets input run ahead of the back end.
// Reset: arst_n asynchronous, active low; clears control state and loads the window to 100..300.
// Depends on lsc_pkg, lsc_front, lsc_fifo, lsc_back.
module line_segment_clipper_core #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lsc_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lsc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic signed [COORD_BITS-1:0]           cfg_data,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [COORD_BITS-1:0]           start_x,
	input  logic signed [COORD_BITS-1:0]           start_y,
	input  logic signed [COORD_BITS-1:0]           end_x,
	input  logic signed [COORD_BITS-1:0]           end_y,
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   accepted,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_start_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_start_y,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_end_x,
	output logic signed [COORD_BITS+FRAC_BITS-1:0] clip_end_y
);
	localparam int W = COORD_BITS + FRAC_BITS;
	localparam int QW = 4 * W + 8;

	logic signed [COORD_BITS-1:0] xl_q, yl_q, xh_q, yh_q;
	logic signed [W-1:0] win_xl, win_yl, win_xh, win_yh;
	logic f_push, f_full, b_pop, b_empty;
	logic [QW-1:0] f_data, b_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xl_q <= COORD_BITS'(lsc_pkg::RST_X_MIN);
			yl_q <= COORD_BITS'(lsc_pkg::RST_Y_MIN);
			xh_q <= COORD_BITS'(lsc_pkg::RST_X_MAX);
			yh_q <= COORD_BITS'(lsc_pkg::RST_Y_MAX);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsc_pkg::REG_X_MIN: xl_q <= cfg_data;
				lsc_pkg::REG_Y_MIN: yl_q <= cfg_data;
				lsc_pkg::REG_X_MAX: xh_q <= cfg_data;
				lsc_pkg::REG_Y_MAX: yh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign win_xl = W'(xl_q) <<< FRAC_BITS;
	assign win_yl = W'(yl_q) <<< FRAC_BITS;
	assign win_xh = W'(xh_q) <<< FRAC_BITS;
	assign win_yh = W'(yh_q) <<< FRAC_BITS;

	lsc_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.win_xl  (win_xl),
		.win_yl  (win_yl),
		.win_xh  (win_xh),
		.win_yh  (win_yh),
		.q_full  (f_full),
		.q_push  (f_push),
		.q_data  (f_data)
	);

	lsc_fifo #(.WIDTH(QW), .DEPTH(lsc_pkg::QUEUE_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_data),
		.q_full  (f_full),
		.rd_en   (b_pop),
		.rd_data (b_data),
		.q_empty (b_empty)
	);

	lsc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.win_xl       (win_xl),
		.win_yl       (win_yl),
		.win_xh       (win_xh),
		.win_yh       (win_yh),
		.q_empty      (b_empty),
		.q_pop        (b_pop),
		.q_data       (b_data),
		.empty        (empty),
		.pop          (pop),
		.accepted     (accepted),
		.clip_start_x (clip_start_x),
		.clip_start_y (clip_start_y),
		.clip_end_x   (clip_end_x),
		.clip_end_y   (clip_end_y)
	);

endmodule

// ===== tb/tb_line_segment_clipper_core.sv =====
// Self-checking testbench for line_segment_clipper_core: Cohen-Sutherland clipping
// checked against an in-bench predictor over several clip windows. Depends on lsc_pkg.
`timescale 1ns / 1ps
module tb_line_segment_clipper_core;

	localparam logic [lsc_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd5;
	localparam longint OUT_HI = (longint'(1) << 23) - 1;
	localparam longint OUT_LO = -(longint'(1) << 23);
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic signed [15:0] x1, y1, x2, y2;
	} segment_t;

	typedef struct {
		logic               vis;
		logic signed [23:0] x1, y1, x2, y2;
	} clipped_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [lsc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic signed [15:0] cfg_data = '0;
	logic push = 0;
	logic full;
	logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic empty;
	logic pop = 0;
	logic accepted;
	logic signed [23:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

	line_segment_clipper_core dut (.*);

	always #2 clk = ~clk;

	// window as the block should hold it
	logic signed [15:0] wx_lo = 16'(lsc_pkg::RST_X_MIN), wy_lo = 16'(lsc_pkg::RST_Y_MIN);
	logic signed [15:0] wx_hi = 16'(lsc_pkg::RST_X_MAX), wy_hi = 16'(lsc_pkg::RST_Y_MAX);

	segment_t pending_segs[$];
	clipped_t expected_clips[$];
	int errors = 0, segs_in = 0, clips_out = 0, visible_cnt = 0, windows = 0;
	bit quiet = 0;

	function automatic logic [3:0] region_of(longint x, longint y, longint xl,
		longint yl, longint xh, longint yh);
		logic [3:0] c;
		c = 4'd0;
		if (y > yh) c |= lsc_pkg::OC_TOP;
		else if (y < yl) c |= lsc_pkg::OC_BOTTOM;
		if (x > xh) c |= lsc_pkg::OC_RIGHT;
		else if (x < xl) c |= lsc_pkg::OC_LEFT;
		return c;
	endfunction

	function automatic longint edge_cross(longint b1, longint b2, longint c1,
		longint c2, longint e);
		longint den, q, v;
		den = c2 - c1;
		q = (den != 0) ? ((b2 - b1) * (e - c1)) / den : 0;
		v = b1 + q;
		if (v > OUT_HI) v = OUT_HI;
		if (v < OUT_LO) v = OUT_LO;
		return v;
	endfunction

	function automatic clipped_t clip_segment(segment_t s);
		longint xl, yl, xh, yh, x1, y1, x2, y2, nx, ny;
		logic [3:0] c1, c2, co;
		bit vis;
		clipped_t r;
		xl = longint'(wx_lo) * 256; yl = longint'(wy_lo) * 256;
		xh = longint'(wx_hi) * 256; yh = longint'(wy_hi) * 256;
		x1 = longint'(s.x1) * 256; y1 = longint'(s.y1) * 256;
		x2 = longint'(s.x2) * 256; y2 = longint'(s.y2) * 256;
		c1 = region_of(x1, y1, xl, yl, xh, yh);
		c2 = region_of(x2, y2, xl, yl, xh, yh);
		vis = 0;
		for (int step = 0; step <= lsc_pkg::MAX_STEPS; step++) begin
			if (c1 == 0 && c2 == 0) begin
				vis = 1;
				break;
			end
			if ((c1 & c2) != 0 || step == lsc_pkg::MAX_STEPS) break;
			co = (c1 != 0) ? c1 : c2;
			if (co & lsc_pkg::OC_TOP) begin
				nx = edge_cross(x1, x2, y1, y2, yh); ny = yh;
			end else if (co & lsc_pkg::OC_BOTTOM) begin
				nx = edge_cross(x1, x2, y1, y2, yl); ny = yl;
			end else if (co & lsc_pkg::OC_RIGHT) begin
				ny = edge_cross(y1, y2, x1, x2, xh); nx = xh;
			end else begin
				ny = edge_cross(y1, y2, x1, x2, xl); nx = xl;
			end
			if (c1 != 0) begin
				x1 = nx; y1 = ny; c1 = region_of(x1, y1, xl, yl, xh, yh);
			end else begin
				x2 = nx; y2 = ny; c2 = region_of(x2, y2, xl, yl, xh, yh);
			end
		end
		r.vis = vis;
		r.x1 = vis ? x1[23:0] : '0; r.y1 = vis ? y1[23:0] : '0;
		r.x2 = vis ? x2[23:0] : '0; r.y2 = vis ? y2[23:0] : '0;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("MISMATCH word %0d %s: got %0d expected %0d", clips_out, what, got, want);
	endtask

	// sender
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
		end else begin
			if (push && !full) begin
				expected_clips.push_back(clip_segment(pending_segs[0]));
				void'(pending_segs.pop_front());
				segs_in++;
			end
			if (send_gap > 0) begin
				send_gap--;
				push <= 0;
			end else if (!quiet && $urandom_range(0, 19) == 0) begin
				send_gap = $urandom_range(1, 12) - 1;
				push <= 0;
			end else if (pending_segs.size() > 0) begin
				push <= 1;
				start_x <= pending_segs[0].x1; start_y <= pending_segs[0].y1;
				end_x <= pending_segs[0].x2; end_y <= pending_segs[0].y2;
			end else begin
				push <= 0;
			end
		end
	end

	// receiver and checker
	int pop_gap = 0;
	bit held = 0;
	always @(posedge clk or negedge arst_n) begin
		clipped_t w;
		if (!arst_n) begin
			pop <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_clips.size() == 0) begin
					report("word with nothing pending", 1, 0);
				end else begin
					w = expected_clips.pop_front();
					if (accepted !== w.vis) report("accepted", accepted, w.vis);
					if (clip_start_x !== w.x1) report("clip_start_x", clip_start_x, w.x1);
					if (clip_start_y !== w.y1) report("clip_start_y", clip_start_y, w.y1);
					if (clip_end_x !== w.x2) report("clip_end_x", clip_end_x, w.x2);
					if (clip_end_y !== w.y2) report("clip_end_y", clip_end_y, w.y2);
					if (w.vis) visible_cnt++;
				end
				clips_out++;
			end
			// one long hold-off so the input side backs up
			if (!held && clips_out == 250) begin
				held = 1;
				pop_gap = HOLD_CYCLES;
			end
			if (pop_gap > 0) begin
				pop_gap--;
				pop <= 0;
			end else if (!quiet && $urandom_range(0, 19) == 0) begin
				pop_gap = $urandom_range(1, 12) - 1;
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	int stall_cnt = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

	task automatic write_reg(logic [lsc_pkg::CFG_IDX_BITS-1:0] idx, logic signed [15:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lsc_pkg::REG_X_MIN: wx_lo = val;
			lsc_pkg::REG_Y_MIN: wy_lo = val;
			lsc_pkg::REG_X_MAX: wx_hi = val;
			lsc_pkg::REG_Y_MAX: wy_hi = val;
			default: ;
		endcase
		cfg_valid <= 0;
	endtask

	task automatic set_window(int xl, int yl, int xh, int yh);
		write_reg(lsc_pkg::REG_X_MIN, xl[15:0]); write_reg(lsc_pkg::REG_Y_MIN, yl[15:0]);
		write_reg(lsc_pkg::REG_X_MAX, xh[15:0]); write_reg(lsc_pkg::REG_Y_MAX, yh[15:0]);
		windows++;
	endtask

	task automatic add_seg(int a, int b, int c, int d);
		segment_t s;
		s.x1 = a[15:0]; s.y1 = b[15:0]; s.x2 = c[15:0]; s.y2 = d[15:0];
		pending_segs.push_back(s);
	endtask

	// coordinate near a window span, clamped to 16 bits
	function automatic int near_span(int a, int b);
		int lo, hi, m, v;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m = (hi - lo) / 2 + 4;
		v = lo - m + int'($urandom_range(0, hi - lo + 2 * m));
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	function automatic int any_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				add_seg(any_coord(), any_coord(), any_coord(), any_coord());
			else
				add_seg(near_span(wx_lo, wx_hi), near_span(wy_lo, wy_hi),
					near_span(wx_lo, wx_hi), near_span(wy_lo, wy_hi));
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_segs.size() != 0 || expected_clips.size() != 0 || push);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset window 100..300
		add_seg(150, 150, 250, 250);        // inside
		add_seg(0, 0, 50, 50);              // both lower-left: reject
		add_seg(200, 0, 200, 400);          // vertical through bottom and top
		add_seg(0, 200, 400, 200);          // horizontal through left and right
		add_seg(0, 0, 400, 400);            // diagonal through corners
		add_seg(50, 250, 250, 350);         // left and top
		add_seg(0, 350, 350, 0);            // misses the corner region test
		add_seg(0, 390, 390, 0);            // three clip steps
		add_seg(120, 310, 310, 120);        // cuts the top-right corner
		add_seg(-32768, -32768, 32767, 32767);
		add_seg(32767, -32768, -32768, 32767);
		add_seg(-32768, 200, 32767, 201);
		add_seg(200, 32767, 201, -32768);
		add_seg(100, 100, 300, 300);        // exactly on edges
		add_seg(200, 200, 200, 200);        // point inside
		add_seg(400, 400, 400, 400);        // point outside
		add_seg(-1, -1, 32767, 32767);
		add_seg(0, 0, -1, -1);
		add_random(160);
		drain();

		write_reg(REG_UNUSED, 16'sh1234);   // must be ignored
		set_window(-32768, -32768, 32767, 32767);
		add_seg(-32768, -32768, 32767, 32767);
		add_seg(-32768, 32767, 32767, -32768);
		add_random(150);
		drain();

		set_window(-5, -3, 7, 4);
		add_random(200);
		drain();

		set_window(32767, 32767, -32768, -32768);  // inverted window
		add_seg(0, 0, 10, 10);
		add_seg(-32768, 0, 32767, 5);
		add_random(150);
		drain();

		set_window(0, 0, 0, 0);
		add_seg(-1, -1, 1, 1);
		add_seg(0, 0, 0, 0);
		add_random(150);
		drain();

		set_window(-2000, 500, 1500, 900);
		add_random(120);
		drain();

		quiet = 1;
		set_window(-32768, 100, 32767, 120);
		add_random(150);
		drain();
		repeat (400) @(posedge clk);

		$display("%0d segments checked over %0d windows, %0d visible and %0d rejected",
			clips_out, windows + 1, visible_cnt, clips_out - visible_cnt);
		if (errors == 0 && expected_clips.size() == 0)
			$display("ALL CHECKS PASSED");
		else begin
			$display("%0d mismatches, %0d words missing", errors, expected_clips.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
